@@ sv/mscp_pkg.sv @@
// Shared types and constants of the MPEG-1 start code parser.
package mscp_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] SEQ_CODE    = 8'hB3;
   localparam logic [7:0] GOP_CODE    = 8'hB8;
   localparam logic [7:0] PIC_CODE    = 8'h00;
   localparam logic [7:0] SLICE_FIRST = 8'h01;
   localparam logic [7:0] SLICE_LAST  = 8'hAF;
   localparam logic [7:0] PREFIX_LAST = 8'h01;

   localparam logic [2:0] KIND_SEQ   = 3'd0;
   localparam logic [2:0] KIND_GOP   = 3'd1;
   localparam logic [2:0] KIND_PIC   = 3'd2;
   localparam logic [2:0] KIND_SLICE = 3'd3;
   localparam logic [2:0] KIND_OTHER = 3'd4;

   localparam logic [2:0] TYPE_I = 3'd1;
   localparam logic [2:0] TYPE_P = 3'd2;

   localparam logic [1:0] CLASS_I = 2'd0;
   localparam logic [1:0] CLASS_P = 2'd1;
   localparam logic [1:0] CLASS_B = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  code;
      logic [23:0] payload;
      logic [7:0]  last_byte;
   } event_type;

endpackage

@@ sv/mscp_front.sv @@
// Byte scanner that finds start code prefixes and collects header bytes.
module mscp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           stream_byte,
   output logic                 emit,
   output mscp_pkg::event_type  event_out
);

   typedef enum logic [1:0] {
      PH_SCAN,
      PH_CODE,
      PH_SEQ,
      PH_PIC
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] window_ff, window_in;
   logic [1:0]  count_ff, count_in;
   logic [7:0]  code_ff, code_in;
   logic [23:0] payload_ff, payload_in;

   always_comb begin
      phase_in   = phase_ff;
      window_in  = window_ff;
      count_in   = count_ff;
      code_in    = code_ff;
      payload_in = payload_ff;
      emit       = 1'b0;
      event_out  = '{kind: mscp_pkg::KIND_OTHER, code: stream_byte,
                     payload: payload_ff, last_byte: stream_byte};
      if (accept) begin
         case (phase_ff)
            PH_CODE: begin
               code_in = stream_byte;
               if (stream_byte == mscp_pkg::SEQ_CODE) begin
                  phase_in   = PH_SEQ;
                  count_in   = 2'd0;
                  payload_in = '0;
               end else if (stream_byte == mscp_pkg::PIC_CODE) begin
                  phase_in   = PH_PIC;
                  count_in   = 2'd0;
                  payload_in = '0;
               end else begin
                  phase_in   = PH_SCAN;
                  window_in  = 16'hFFFF;
                  count_in   = 2'd0;
                  payload_in = '0;
                  emit       = 1'b1;
                  if (stream_byte == mscp_pkg::GOP_CODE) begin
                     event_out.kind = mscp_pkg::KIND_GOP;
                  end else if (stream_byte inside
                               {[mscp_pkg::SLICE_FIRST:mscp_pkg::SLICE_LAST]}) begin
                     event_out.kind = mscp_pkg::KIND_SLICE;
                  end
               end
            end
            PH_SEQ: begin
               if (count_ff != 2'd3) begin
                  payload_in = {payload_ff[15:0], stream_byte};
                  count_in   = count_ff + 2'd1;
               end else begin
                  emit           = 1'b1;
                  event_out.kind = mscp_pkg::KIND_SEQ;
                  event_out.code = code_ff;
                  phase_in       = PH_SCAN;
                  window_in      = 16'hFFFF;
                  count_in       = 2'd0;
                  payload_in     = '0;
               end
            end
            PH_PIC: begin
               if (count_ff == 2'd0) begin
                  payload_in = {payload_ff[15:0], stream_byte};
                  count_in   = 2'd1;
               end else begin
                  emit           = 1'b1;
                  event_out.kind = mscp_pkg::KIND_PIC;
                  event_out.code = code_ff;
                  phase_in       = PH_SCAN;
                  window_in      = 16'hFFFF;
                  count_in       = 2'd0;
                  payload_in     = '0;
               end
            end
            default: begin
               if (window_ff == 16'h0000 && stream_byte == mscp_pkg::PREFIX_LAST) begin
                  phase_in = PH_CODE;
               end else begin
                  window_in = {window_ff[7:0], stream_byte};
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SCAN;
         window_ff  <= 16'hFFFF;
         count_ff   <= 2'd0;
         code_ff    <= 8'h00;
         payload_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         window_ff  <= window_in;
         count_ff   <= count_in;
         code_ff    <= code_in;
         payload_ff <= payload_in;
      end
   end

endmodule

@@ sv/mscp_queue.sv @@
// Small event queue between the scanner and the result stage.
module mscp_queue #(
   parameter int DEPTH = mscp_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mscp_pkg::event_type  push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output mscp_pkg::event_type  head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   mscp_pkg::event_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ sv/mscp_back.sv @@
// Result stage that decodes header fields into the output register.
module mscp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  mscp_pkg::event_type  q_head,
   output logic                 q_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [2:0]           rsp_event_kind,
   output logic [7:0]           rsp_code_value,
   output logic [11:0]          rsp_frame_width,
   output logic [11:0]          rsp_frame_height,
   output logic [3:0]           rsp_rate_code,
   output logic [2:0]           rsp_coding_type,
   output logic [1:0]           rsp_picture_class
);

   logic        valid_ff, valid_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  code_ff, code_in;
   logic [11:0] width_ff, width_in;
   logic [11:0] height_ff, height_in;
   logic [3:0]  rate_ff, rate_in;
   logic [2:0]  ctype_ff, ctype_in;
   logic [1:0]  class_ff, class_in;
   logic        slot_free;
   logic [2:0]  pic_type;

   assign slot_free = !valid_ff || rsp_pop;
   assign q_pop     = slot_free && !q_empty;
   assign pic_type  = q_head.last_byte[5:3];

   always_comb begin
      valid_in  = valid_ff && !rsp_pop;
      kind_in   = kind_ff;
      code_in   = code_ff;
      width_in  = width_ff;
      height_in = height_ff;
      rate_in   = rate_ff;
      ctype_in  = ctype_ff;
      class_in  = class_ff;
      if (q_pop) begin
         valid_in  = 1'b1;
         kind_in   = q_head.kind;
         code_in   = q_head.code;
         width_in  = '0;
         height_in = '0;
         rate_in   = '0;
         ctype_in  = '0;
         class_in  = mscp_pkg::CLASS_I;
         if (q_head.kind == mscp_pkg::KIND_SEQ) begin
            width_in  = {q_head.payload[23:16], q_head.payload[15:12]};
            height_in = {q_head.payload[11:8], q_head.payload[7:0]};
            rate_in   = q_head.last_byte[3:0];
         end else if (q_head.kind == mscp_pkg::KIND_PIC) begin
            ctype_in = pic_type;
            if (pic_type == mscp_pkg::TYPE_I) begin
               class_in = mscp_pkg::CLASS_I;
            end else if (pic_type == mscp_pkg::TYPE_P) begin
               class_in = mscp_pkg::CLASS_P;
            end else begin
               class_in = mscp_pkg::CLASS_B;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      kind_ff   <= kind_in;
      code_ff   <= code_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      rate_ff   <= rate_in;
      ctype_ff  <= ctype_in;
      class_ff  <= class_in;
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_event_kind    = kind_ff;
   assign rsp_code_value    = code_ff;
   assign rsp_frame_width   = width_ff;
   assign rsp_frame_height  = height_ff;
   assign rsp_rate_code     = rate_ff;
   assign rsp_coding_type   = ctype_ff;
   assign rsp_picture_class = class_ff;

endmodule

@@ sv/mpeg1_start_code_parser.sv @@
// Top level of the MPEG-1 video start code and header parser.
// The parser takes one stream byte per clock and reports one result per start code:
// group of pictures, slice and other codes right after the code byte, a sequence
// header after its fourth payload byte and a picture after its second. Requests are
// accepted every cycle while req_full is low; the scanner never stalls on its own.
// Results pass through an event queue of QUEUE_DEPTH entries and a result register,
// so req_full rises only when QUEUE_DEPTH plus one results are waiting untaken. With
// the queue empty and the result register free, a result completed by an accepted request
// is written into the event queue and then registered in the result register that drives rsp_.
module mpeg1_start_code_parser #(
   parameter int QUEUE_DEPTH = mscp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_event_kind,
   output logic [7:0]  rsp_code_value,
   output logic [11:0] rsp_frame_width,
   output logic [11:0] rsp_frame_height,
   output logic [3:0]  rsp_rate_code,
   output logic [2:0]  rsp_coding_type,
   output logic [1:0]  rsp_picture_class
);

   logic                accept;
   logic                emit;
   mscp_pkg::event_type front_event;
   logic                q_empty;
   logic                q_pop;
   mscp_pkg::event_type q_head;

   assign accept = req_push && !req_full;

   mscp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .stream_byte (req_stream_byte),
      .emit        (emit),
      .event_out   (front_event)
   );

   mscp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (front_event),
      .pop       (q_pop),
      .full      (req_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   mscp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_code_value    (rsp_code_value),
      .rsp_frame_width   (rsp_frame_width),
      .rsp_frame_height  (rsp_frame_height),
      .rsp_rate_code     (rsp_rate_code),
      .rsp_coding_type   (rsp_coding_type),
      .rsp_picture_class (rsp_picture_class)
   );

endmodule

@@ dv/tb_mpeg1_start_code_parser.sv @@
// Testbench of the MPEG-1 start code parser: byte streams checked against a local header parser.
module tb_mpeg1_start_code_parser;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic [2:0] {
      PH_SCAN = 3'd0,
      PH_CODE = 3'd1,
      PH_SEQ  = 3'd2,
      PH_PIC  = 3'd3
   } parse_phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  code;
      logic [11:0] width;
      logic [11:0] height;
      logic [3:0]  rate;
      logic [2:0]  ctype;
      logic [1:0]  pclass;
   } header_event_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_push        = 1'b0;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        rsp_pop         = 1'b0;
   logic        req_full;
   logic        rsp_empty;
   logic [2:0]  rsp_event_kind;
   logic [7:0]  rsp_code_value;
   logic [11:0] rsp_frame_width;
   logic [11:0] rsp_frame_height;
   logic [3:0]  rsp_rate_code;
   logic [2:0]  rsp_coding_type;
   logic [1:0]  rsp_picture_class;

   header_event_type expected_events[$];

   logic [15:0]     scan_window;
   parse_phase_type parse_phase;
   logic [2:0]      payload_count;
   logic [7:0]      held_code;
   logic [23:0]     held_payload;

   int error_count    = 0;
   int cycle_count    = 0;
   int bytes_sent     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   mpeg1_start_code_parser i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_stream_byte   (req_stream_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_code_value    (rsp_code_value),
      .rsp_frame_width   (rsp_frame_width),
      .rsp_frame_height  (rsp_frame_height),
      .rsp_rate_code     (rsp_rate_code),
      .rsp_coding_type   (rsp_coding_type),
      .rsp_picture_class (rsp_picture_class)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_mpeg1_start_code_parser: errors");
      $finish;
   end

   function automatic void restart_scan();
      scan_window   = 16'hFFFF;
      parse_phase   = PH_SCAN;
      payload_count = 3'd0;
      held_payload  = 24'h000000;
   endfunction

   function automatic void parse_byte(input logic [7:0] b);
      header_event_type ev;
      logic [2:0]       ct;
      ev = '0;
      case (parse_phase)
         PH_CODE: begin
            held_code = b;
            if (b == mscp_pkg::SEQ_CODE) begin
               parse_phase   = PH_SEQ;
               payload_count = 3'd0;
               held_payload  = 24'h000000;
            end else if (b == mscp_pkg::PIC_CODE) begin
               parse_phase   = PH_PIC;
               payload_count = 3'd0;
               held_payload  = 24'h000000;
            end else begin
               restart_scan();
               ev.code = b;
               if (b == mscp_pkg::GOP_CODE) begin
                  ev.kind = mscp_pkg::KIND_GOP;
               end else if (b <= mscp_pkg::SLICE_LAST) begin
                  ev.kind = mscp_pkg::KIND_SLICE;
               end else begin
                  ev.kind = mscp_pkg::KIND_OTHER;
               end
               expected_events.push_back(ev);
            end
         end
         PH_SEQ: begin
            if (payload_count < 3'd3) begin
               held_payload  = {held_payload[15:0], b};
               payload_count = payload_count + 3'd1;
            end else begin
               ev.kind   = mscp_pkg::KIND_SEQ;
               ev.code   = held_code;
               ev.width  = {held_payload[23:16], held_payload[15:12]};
               ev.height = {held_payload[11:8], held_payload[7:0]};
               ev.rate   = b[3:0];
               expected_events.push_back(ev);
               restart_scan();
            end
         end
         PH_PIC: begin
            if (payload_count < 3'd1) begin
               held_payload  = {held_payload[15:0], b};
               payload_count = payload_count + 3'd1;
            end else begin
               ct       = b[5:3];
               ev.kind  = mscp_pkg::KIND_PIC;
               ev.code  = held_code;
               ev.ctype = ct;
               if (ct == mscp_pkg::TYPE_I) begin
                  ev.pclass = mscp_pkg::CLASS_I;
               end else if (ct == mscp_pkg::TYPE_P) begin
                  ev.pclass = mscp_pkg::CLASS_P;
               end else begin
                  ev.pclass = mscp_pkg::CLASS_B;
               end
               expected_events.push_back(ev);
               restart_scan();
            end
         end
         default: begin
            if (scan_window == 16'h0000 && b == mscp_pkg::PREFIX_LAST) begin
               parse_phase = PH_CODE;
            end else begin
               parse_phase = PH_SCAN;
               scan_window = {scan_window[7:0], b};
            end
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      header_event_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_events.size() == 0) begin
            $display("%0t: result kind %0h code %0h expected nothing, got it", $time,
                     rsp_event_kind, rsp_code_value);
            error_count++;
         end else begin
            want = expected_events.pop_front();
            check_field("event_kind", want.kind, rsp_event_kind);
            check_field("code_value", want.code, rsp_code_value);
            check_field("frame_width", want.width, rsp_frame_width);
            check_field("frame_height", want.height, rsp_frame_height);
            check_field("rate_code", want.rate, rsp_rate_code);
            check_field("coding_type", want.ctype, rsp_coding_type);
            check_field("picture_class", want.pclass, rsp_picture_class);
         end
      end
      rsp_pop <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_stream_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      parse_byte(b);
      bytes_sent++;
   endtask

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(3))
         0: return 8'h00;
         1: return mscp_pkg::PREFIX_LAST;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic wait_for_idle();
      req_push <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_header();
      int         zeros;
      int         payload_len;
      logic [7:0] code;
      repeat ($urandom_range(3)) send_byte(noise_byte());
      zeros = $urandom_range(4, 2);
      repeat (zeros) send_byte(8'h00);
      send_byte(mscp_pkg::PREFIX_LAST);
      case ($urandom_range(5))
         0: code = mscp_pkg::SEQ_CODE;
         1: code = mscp_pkg::PIC_CODE;
         2: code = mscp_pkg::GOP_CODE;
         3: code = 8'($urandom_range(mscp_pkg::SLICE_LAST, mscp_pkg::SLICE_FIRST));
         4: begin
            do code = 8'($urandom_range(255, 8'hB0));
            while (code == mscp_pkg::SEQ_CODE || code == mscp_pkg::GOP_CODE);
         end
         default: code = 8'($urandom_range(255));
      endcase
      send_byte(code);
      if (code == mscp_pkg::SEQ_CODE) begin
         payload_len = 4;
      end else if (code == mscp_pkg::PIC_CODE) begin
         payload_len = 2;
      end else begin
         payload_len = 0;
      end
      if (payload_len != 0 && $urandom_range(9) == 0) begin
         payload_len = $urandom_range(payload_len - 1);
      end
      repeat (payload_len) begin
         if ($urandom_range(4) == 0) begin
            send_byte(noise_byte());
         end else begin
            send_byte(8'($urandom_range(255)));
         end
      end
   endtask

   task automatic test_directed();
      logic [7:0] stream[$];
      stream = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hB3, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h08,
                 8'h00, 8'h00, 8'h01, 8'hB8,
                 8'h00, 8'h00, 8'h01, 8'hFF};
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      foreach (stream[i]) send_byte(stream[i]);
      wait_for_idle();
   endtask

   task automatic test_random(input int count, input int idle_pct, input int stall_pct);
      int target;
      int pick;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      target         = bytes_sent + count;
      while (bytes_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            send_header();
         end else if (pick < 90) begin
            repeat ($urandom_range(6, 1)) begin
               if ($urandom_range(2) == 0) begin
                  send_byte(mscp_pkg::PREFIX_LAST);
               end else begin
                  send_byte(8'h00);
               end
            end
         end else begin
            repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
         end
      end
      wait_for_idle();
   endtask

   initial begin
      restart_scan();
      held_code = 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(460, 0, 0);
      test_random(460, 79, 0);
      test_random(460, 0, 79);
      test_random(470, 24, 24);
      if (error_count == 0) begin
         $display("tb_mpeg1_start_code_parser: clean");
      end else begin
         $display("tb_mpeg1_start_code_parser: errors");
      end
      $finish;
   end

endmodule
